// ===== rtl/delay_and_sum_receiver_array_defines.svh =====
// ----------------------------------------------------------------------------
// delay_and_sum_receiver_array_defines
// assertion macros used by the receiver array rtl
// ----------------------------------------------------------------------------
`ifndef DELAY_AND_SUM_RECEIVER_ARRAY_DEFINES_SVH
`define DELAY_AND_SUM_RECEIVER_ARRAY_DEFINES_SVH

// condition must never hold outside reset
`define DSRA_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

// antecedent implies consequent in the same cycle
`define DSRA_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define DSRA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/dsra_pkg.sv =====
// ----------------------------------------------------------------------------
// dsra_pkg
// shared widths, register indexes and types of the receiver array beamformer
// ----------------------------------------------------------------------------
package dsra_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int TIME_W     = 12;
    localparam int RX_W       = 4;
    localparam int AMP_W      = 20;
    localparam int STEP_W     = 24;
    localparam int LEN_W      = 13;
    localparam int CNT_W      = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam int AMP_MAX = 524287;
    localparam int AMP_MIN = -524288;

    localparam logic [CFG_IDX_W-1:0] REG_DELAY_STEP     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_RECORD_LENGTH  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_RECEIVER_COUNT = CFG_IDX_W'(2);

    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(4096);
    localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(16);

    localparam logic KIND_RECORD = 1'b0;
    localparam logic KIND_SYNTH  = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_FINISH
    } seq_state_t;

    // how one receiver tap contributes
    typedef enum logic [1:0] {
        TAP_ZERO,
        TAP_HOLD,
        TAP_LERP
    } tap_kind_t;

    typedef struct packed {
        logic      clear;
        logic      valid;
        logic      last;
        tap_kind_t kind;
    } acc_ctrl_t;

    typedef struct packed {
        logic done;
        logic busy;
    } acc_stat_t;

endpackage

// ===== rtl/dsra_store.sv =====
// ----------------------------------------------------------------------------
// dsra_store
// dual-port sample store: port a writes or reads, port b reads, registered data
// ----------------------------------------------------------------------------
module dsra_store #(
    parameter int DEPTH = 65536,
    parameter int AW    = 16
) (
    input  logic                                clk,
    input  logic                                we,
    input  logic [AW-1:0]                       addr_a,
    input  logic signed [dsra_pkg::SAMPLE_W-1:0] wdata,
    input  logic [AW-1:0]                       addr_b,
    output logic signed [dsra_pkg::SAMPLE_W-1:0] q_a,
    output logic signed [dsra_pkg::SAMPLE_W-1:0] q_b
);
    import dsra_pkg::*;

    logic signed [SAMPLE_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr_a] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        q_a <= mem[addr_a];
        q_b <= mem[addr_b];
    end

endmodule

// ===== rtl/dsra_accum.sv =====
// ----------------------------------------------------------------------------
// dsra_accum
// per-tap interpolation multiply and saturating sum over receivers
// ----------------------------------------------------------------------------
module dsra_accum #(
    parameter int FRACTION_BITS = 16,
    parameter int MAX_RECEIVERS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  dsra_pkg::acc_ctrl_t                 ctrl,
    input  logic [FRACTION_BITS-1:0]            frac,
    input  logic signed [dsra_pkg::SAMPLE_W-1:0] q0,
    input  logic signed [dsra_pkg::SAMPLE_W-1:0] q1,
    output dsra_pkg::acc_stat_t                 stat,
    output logic signed [dsra_pkg::AMP_W-1:0]    result
);
    import dsra_pkg::*;

    localparam int DW  = SAMPLE_W + 1;
    localparam int PRW = DW + FRACTION_BITS + 1;
    localparam int VW  = SAMPLE_W + 2;
    localparam int SW0 = SAMPLE_W + $clog2(MAX_RECEIVERS) + 1;
    localparam int SW  = ((SW0 > AMP_W) ? SW0 : AMP_W) + 1;

    localparam logic signed [SW-1:0] SUM_HI = SW'(AMP_MAX);
    localparam logic signed [SW-1:0] SUM_LO = SW'(AMP_MIN);

    logic                     a_v_reg, a_v_next;
    logic                     a_last_reg, a_last_next;
    tap_kind_t                a_kind_reg, a_kind_next;
    logic signed [SAMPLE_W-1:0] s0_reg, s0_next;
    logic signed [PRW-1:0]    prod_reg, prod_next;
    logic signed [SW-1:0]     sum_reg, sum_next;
    logic signed [AMP_W-1:0]  result_reg, result_next;
    logic                     done_reg, done_next;

    logic signed [DW-1:0]            diff;
    logic signed [FRACTION_BITS:0]   frac_s;
    logic signed [VW-1:0]            val;
    logic signed [SW-1:0]            sum_add;
    logic signed [AMP_W-1:0]         sum_sat;

    // first stage: s0 + (s1 - s0) * f, multiply registered
    always_comb
    begin
        diff        = DW'(q1) - DW'(q0);
        frac_s      = signed'({1'b0, frac});
        prod_next   = PRW'(diff) * PRW'(frac_s);
        s0_next     = q0;
        a_v_next    = ctrl.valid;
        a_last_next = ctrl.last;
        a_kind_next = ctrl.kind;
    end

    // second stage: floor shift, accumulate, saturate on the last tap
    always_comb
    begin
        unique case (a_kind_reg)
            TAP_ZERO: val = '0;
            TAP_HOLD: val = VW'(s0_reg);
            TAP_LERP: val = VW'(s0_reg) + VW'(prod_reg >>> FRACTION_BITS);
            default:  val = '0;
        endcase

        sum_add = sum_reg + SW'(val);

        priority if (sum_add > SUM_HI)
        begin
            sum_sat = AMP_W'(AMP_MAX);
        end
        else if (sum_add < SUM_LO)
        begin
            sum_sat = AMP_W'(AMP_MIN);
        end
        else
        begin
            sum_sat = sum_add[AMP_W-1:0];
        end

        priority if (ctrl.clear)
        begin
            sum_next    = '0;
            result_next = '0;
        end
        else if (a_v_reg)
        begin
            sum_next    = sum_add;
            result_next = a_last_reg ? sum_sat : result_reg;
        end
        else
        begin
            sum_next    = sum_reg;
            result_next = result_reg;
        end

        done_next = a_v_reg && a_last_reg && !ctrl.clear;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            a_v_reg  <= a_v_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_last_reg <= a_last_next;
        a_kind_reg <= a_kind_next;
        s0_reg     <= s0_next;
        prod_reg   <= prod_next;
        sum_reg    <= sum_next;
        result_reg <= result_next;
    end

    assign stat   = '{done: done_reg, busy: a_v_reg};
    assign result = result_reg;

endmodule

// ===== rtl/delay_and_sum_receiver_array.sv =====
// ----------------------------------------------------------------------------
// delay_and_sum_receiver_array
// receiver sample store with a delay-and-sum synthesizer using linear
// interpolation between neighbouring samples
// ----------------------------------------------------------------------------
// A record word writes one sample into the store and gives no result. A
// synth word walks the receivers one per cycle, reading both neighbouring
// samples of a receiver in the same cycle through the two ports of the
// store; it holds the input stalled until its taps have passed the multiply
// and accumulate stages and its result is loaded into the output register.
// One word is worked on at a time, and a finished result waits in the
// output register while the next word is taken. After reset the store is
// cleared one entry per cycle, all MAX_RECEIVERS * MAX_SAMPLES entries
// (65536 at the defaults), during which no word is accepted; configuration
// writes are taken at any time.
// ----------------------------------------------------------------------------
`include "delay_and_sum_receiver_array_defines.svh"

module delay_and_sum_receiver_array #(
    parameter int MAX_RECEIVERS = 16,
    parameter int MAX_SAMPLES   = 4096,
    parameter int FRACTION_BITS = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,

    input  logic                                   cfg_write,
    input  logic [dsra_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [dsra_pkg::CFG_DATA_W-1:0]        cfg_data,

    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic                                   kind,
    input  logic [dsra_pkg::RX_W-1:0]              receiver_index,
    input  logic [dsra_pkg::TIME_W-1:0]            time_index,
    input  logic signed [dsra_pkg::SAMPLE_W-1:0]   sample_value,

    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [dsra_pkg::AMP_W-1:0]      amplitude
);
    import dsra_pkg::*;

    localparam int DEPTH = MAX_RECEIVERS * MAX_SAMPLES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IW    = $clog2(MAX_SAMPLES);
    localparam int GW    = $clog2(MAX_RECEIVERS + 1);
    localparam int IBASE = (IW > TIME_W) ? IW : TIME_W;
    localparam int SPAN  = STEP_W + GW;
    localparam int PW    = ((IBASE + FRACTION_BITS > SPAN) ? IBASE + FRACTION_BITS : SPAN) + 2;
    localparam int IPW   = PW - FRACTION_BITS;

    localparam logic [AW-1:0] CLR_LAST = AW'(DEPTH - 1);
    localparam logic [AW-1:0] ROW_STEP = AW'(MAX_SAMPLES);

    seq_state_t                 state_reg, state_next;

    logic signed [STEP_W-1:0]   delay_step_reg;
    logic [LEN_W-1:0]           record_length_reg;
    logic [CNT_W-1:0]           receiver_count_reg;

    logic [AW-1:0]              clr_addr_reg, clr_addr_next;
    logic signed [PW-1:0]       pos_reg, pos_next;
    logic [AW-1:0]              row_reg, row_next;
    logic [GW-1:0]              g_reg, g_next;
    logic [GW-1:0]              last_g_reg, last_g_next;
    logic [IPW-1:0]             lastidx_reg, lastidx_next;

    logic                       tap_v_reg, tap_v_next;
    logic                       tap_last_reg, tap_last_next;
    tap_kind_t                  tap_kind_reg, tap_kind_next;
    logic [FRACTION_BITS-1:0]   tap_frac_reg, tap_frac_next;

    logic                       out_valid_reg, out_valid_next;
    logic signed [AMP_W-1:0]    amplitude_reg, amplitude_next;

    logic                       in_accept;
    logic                       synth_go;
    logic                       rec_ok;
    logic [AW-1:0]              rec_addr;
    logic                       out_free;
    logic                       out_load;
    logic [GW-1:0]              rc_eff;

    logic [IPW-1:0]             ipart;
    tap_kind_t                  cur_kind;
    logic [AW-1:0]              rd_addr0;
    logic [AW-1:0]              rd_addr1;

    logic                       mem_we;
    logic [AW-1:0]              mem_addr_a;
    logic signed [SAMPLE_W-1:0] mem_wdata;
    logic signed [SAMPLE_W-1:0] q_a;
    logic signed [SAMPLE_W-1:0] q_b;

    acc_ctrl_t                  acc_ctrl;
    acc_stat_t                  acc_stat;
    logic signed [AMP_W-1:0]    acc_result;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_step_reg     <= '0;
            record_length_reg  <= LEN_RESET;
            receiver_count_reg <= CNT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_DELAY_STEP:     delay_step_reg     <= signed'(cfg_data[STEP_W-1:0]);
                REG_RECORD_LENGTH:  record_length_reg  <= cfg_data[LEN_W-1:0];
                REG_RECEIVER_COUNT: receiver_count_reg <= cfg_data[CNT_W-1:0];
                default:            ;
            endcase
        end
    end

    // tap decode for the receiver being issued
    always_comb
    begin
        ipart = pos_reg[PW-1:FRACTION_BITS];

        priority if (pos_reg[PW-1])
        begin
            cur_kind = TAP_ZERO;
        end
        else if (ipart > lastidx_reg)
        begin
            cur_kind = TAP_ZERO;
        end
        else if (ipart == lastidx_reg)
        begin
            cur_kind = TAP_HOLD;
        end
        else
        begin
            cur_kind = TAP_LERP;
        end

        rd_addr0 = row_reg + AW'(ipart[IW-1:0]);
        rd_addr1 = rd_addr0 + AW'(1);
    end

    // record address and range check, clamped register values
    always_comb
    begin
        rec_ok   = (int'(receiver_index) < MAX_RECEIVERS) && (int'(time_index) < MAX_SAMPLES);
        rec_addr = AW'(receiver_index) * ROW_STEP + AW'(time_index);

        if (int'(receiver_count_reg) > MAX_RECEIVERS)
        begin
            rc_eff = GW'(MAX_RECEIVERS);
        end
        else
        begin
            rc_eff = GW'(receiver_count_reg);
        end
    end

    // datapath next values
    always_comb
    begin
        clr_addr_next = (state_reg == ST_CLEAR) ? clr_addr_reg + AW'(1) : clr_addr_reg;
        pos_next      = pos_reg;
        row_next      = row_reg;
        g_next        = g_reg;
        last_g_next   = last_g_reg;
        lastidx_next  = lastidx_reg;
        tap_v_next    = 1'b0;
        tap_last_next = (g_reg == last_g_reg);
        tap_kind_next = cur_kind;
        tap_frac_next = pos_reg[FRACTION_BITS-1:0];

        if (synth_go)
        begin
            pos_next    = PW'(time_index) << FRACTION_BITS;
            row_next    = '0;
            g_next      = '0;
            last_g_next = rc_eff - GW'(1);
            priority if (record_length_reg == '0)
            begin
                lastidx_next = '0;
            end
            else if (int'(record_length_reg) > MAX_SAMPLES)
            begin
                lastidx_next = IPW'(MAX_SAMPLES - 1);
            end
            else
            begin
                lastidx_next = IPW'(record_length_reg) - IPW'(1);
            end
        end
        else if (state_reg == ST_ISSUE)
        begin
            // next receiver sits one delay step earlier, one row further on
            pos_next   = pos_reg - PW'(delay_step_reg);
            row_next   = row_reg + ROW_STEP;
            g_next     = g_reg + GW'(1);
            tap_v_next = 1'b1;
        end

        out_valid_next = out_load ? 1'b1 : (out_stall ? out_valid_reg : 1'b0);
        amplitude_next = out_load ? acc_result : amplitude_reg;
    end

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_addr_reg == CLR_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (synth_go)
                begin
                    state_next = (receiver_count_reg == '0) ? ST_FINISH : ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                if (g_reg == last_g_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (acc_stat.done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_stall  = (state_reg != ST_IDLE);
        in_accept = in_valid && !in_stall;
        synth_go  = in_accept && (kind == KIND_SYNTH);
        out_free  = !out_valid_reg || !out_stall;
        out_load  = (state_reg == ST_FINISH) && out_free;

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we     = 1'b1;
                mem_addr_a = clr_addr_reg;
                mem_wdata  = '0;
            end
            ST_IDLE:
            begin
                mem_we     = in_accept && (kind == KIND_RECORD) && rec_ok;
                mem_addr_a = rec_addr;
                mem_wdata  = sample_value;
            end
            ST_ISSUE, ST_DRAIN, ST_FINISH:
            begin
                mem_we     = 1'b0;
                mem_addr_a = rd_addr0;
                mem_wdata  = sample_value;
            end
            default:
            begin
                mem_we     = 1'b0;
                mem_addr_a = rd_addr0;
                mem_wdata  = sample_value;
            end
        endcase

        acc_ctrl = '{clear: synth_go, valid: tap_v_reg, last: tap_last_reg,
                     kind: tap_kind_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            g_reg         <= '0;
            tap_v_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            g_reg         <= g_next;
            tap_v_reg     <= tap_v_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg       <= pos_next;
        row_reg       <= row_next;
        last_g_reg    <= last_g_next;
        lastidx_reg   <= lastidx_next;
        tap_last_reg  <= tap_last_next;
        tap_kind_reg  <= tap_kind_next;
        tap_frac_reg  <= tap_frac_next;
        amplitude_reg <= amplitude_next;
    end

    dsra_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk    (clk),
        .we     (mem_we),
        .addr_a (mem_addr_a),
        .wdata  (mem_wdata),
        .addr_b (rd_addr1),
        .q_a    (q_a),
        .q_b    (q_b)
    );

    dsra_accum #(
        .FRACTION_BITS (FRACTION_BITS),
        .MAX_RECEIVERS (MAX_RECEIVERS)
    ) u_accum (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (acc_ctrl),
        .frac   (tap_frac_reg),
        .q0     (q_a),
        .q1     (q_b),
        .stat   (acc_stat),
        .result (acc_result)
    );

    assign out_valid = out_valid_reg;
    assign amplitude = amplitude_reg;

    `DSRA_ASSERT_NEVER(a_no_write_in_synth,
        (state_reg == ST_ISSUE || state_reg == ST_DRAIN) && mem_we,
        "store written while a synth word is in flight")
    `DSRA_ASSERT_IMPLIES(a_done_in_drain, acc_stat.done, state_reg == ST_DRAIN,
        "sum finished outside drain")
    `DSRA_ASSERT_IMPLIES(a_issue_bound, state_reg == ST_ISSUE, g_reg <= last_g_reg,
        "receiver counter ran past the count")
    `DSRA_ASSERT_IMPLIES(a_pipe_empty, state_reg == ST_IDLE || state_reg == ST_FINISH,
        !acc_stat.busy, "tap still in the pipeline")
    `DSRA_ASSERT_NEXT(a_done_pulse, acc_stat.done, !acc_stat.done,
        "sum done held for more than one cycle")

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the delay-and-sum receiver array
// ----------------------------------------------------------------------------
// Records samples into the receiver store and requests synthesized output
// samples. Each synth word is predicted by a behavioral model of the store
// and the interpolating beam sum, or pinned in the directed table, and each
// amplitude word is checked in order. A short directed table runs under the
// reset settings. Fixed and then random phases follow, each under its own
// register setting, with both sides idling at random.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dsra_pkg::*;

    localparam int N_RX          = 16;
    localparam int N_SAMP        = 4096;
    localparam int FRAC          = 16;
    localparam int CLK_PERIOD    = 12;
    localparam int RESET_CYCLES  = 10;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 400;
    localparam int N_PHASES      = 14;
    localparam int N_FIXED       = 7;
    localparam int HOLD_PHASE    = 8;
    localparam int PHASE_WORDS   = 125;
    localparam int WINDOW        = 24;
    localparam int LIMIT_CYCLES  = 1_200_000;
    localparam int PROBE_ROWS    = 20;

    // index 3 is not decoded by the block
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(3);

    typedef struct packed {
        logic                       kind;
        logic [RX_W-1:0]            rx;
        logic [TIME_W-1:0]          t;
        logic signed [SAMPLE_W-1:0] s;
        logic                       pinned;
        logic signed [AMP_W-1:0]    amp;
    } probe_row_t;

    logic clk = 1'b0;
    logic rst_n;

    logic                       cfg_write;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [CFG_DATA_W-1:0]      cfg_data;

    logic                       in_valid;
    logic                       in_stall;
    logic                       kind;
    logic [RX_W-1:0]            receiver_index;
    logic [TIME_W-1:0]          time_index;
    logic signed [SAMPLE_W-1:0] sample_value;

    logic                       out_valid;
    logic                       out_stall;
    logic signed [AMP_W-1:0]    amplitude;

    // behavioral copy of the store and the registers
    logic signed [SAMPLE_W-1:0] rx_wave [0:N_RX*N_SAMP-1];
    logic signed [STEP_W-1:0]   step_q;
    logic [LEN_W-1:0]           len_q;
    logic [CNT_W-1:0]           cnt_q;

    logic signed [AMP_W-1:0]    amp_expect [$];

    int  fail_count   = 0;
    int  words_sent   = 0;
    int  synth_sent   = 0;
    int  results_seen = 0;
    int  holds_done   = 0;
    int  burst_left   = 0;
    int  win_base     = 0;
    bit  hold_req     = 1'b0;

    probe_row_t probe_rows [PROBE_ROWS] = '{
        // store is clear after reset
        '{KIND_SYNTH,  4'd0,  12'd0,    16'sd0,     1'b1, 20'sd0},
        '{KIND_SYNTH,  4'd15, 12'd4095, 16'sh7FFF,  1'b1, 20'sd0},
        '{KIND_RECORD, 4'd0,  12'd4095, 16'sh7FFF,  1'b0, 20'sd0},
        '{KIND_RECORD, 4'd15, 12'd4095, 16'sh8000,  1'b0, 20'sd0},
        // last sample is held, no interpolation
        '{KIND_SYNTH,  4'd0,  12'd4095, 16'sd0,     1'b1, -20'sd1},
        '{KIND_RECORD, 4'd0,  12'd0,    16'sh8000,  1'b0, 20'sd0},
        '{KIND_RECORD, 4'd15, 12'd0,    16'sh7FFF,  1'b0, 20'sd0},
        '{KIND_SYNTH,  4'd0,  12'd0,    16'sd0,     1'b1, -20'sd1},
        '{KIND_RECORD, 4'd7,  12'd1,    16'sd1000,  1'b0, 20'sd0},
        '{KIND_SYNTH,  4'd0,  12'd1,    16'sd0,     1'b1, 20'sd1000},
        '{KIND_RECORD, 4'd10, 12'd2048, 16'shFFFF,  1'b0, 20'sd0},
        '{KIND_SYNTH,  4'd0,  12'd2048, 16'sd0,     1'b1, -20'sd1},
        '{KIND_RECORD, 4'd5,  12'd4094, 16'sd12345, 1'b0, 20'sd0},
        '{KIND_SYNTH,  4'd0,  12'd4094, 16'sd0,     1'b1, 20'sd12345},
        // overwrite of a stored sample
        '{KIND_RECORD, 4'd5,  12'd4094, 16'sd0,     1'b0, 20'sd0},
        '{KIND_SYNTH,  4'd0,  12'd4094, 16'sd0,     1'b1, 20'sd0},
        '{KIND_RECORD, 4'd15, 12'd4095, 16'sh7FFF,  1'b0, 20'sd0},
        '{KIND_SYNTH,  4'd0,  12'd4095, 16'sd0,     1'b1, 20'sd65534},
        '{KIND_RECORD, 4'd10, 12'd2047, 16'shAAAA,  1'b0, 20'sd0},
        '{KIND_SYNTH,  4'd9,  12'd2047, 16'sh5555,  1'b1, -20'sd21846}
    };

    delay_and_sum_receiver_array #(
        .MAX_RECEIVERS (N_RX),
        .MAX_SAMPLES   (N_SAMP),
        .FRACTION_BITS (FRAC)
    ) i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .kind           (kind),
        .receiver_index (receiver_index),
        .time_index     (time_index),
        .sample_value   (sample_value),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .amplitude      (amplitude)
    );

    always #(CLK_PERIOD / 2.0) clk = ~clk;

    // delayed, interpolated sum over the active receivers at output time t
    function automatic logic signed [AMP_W-1:0] steered_sum(input logic [TIME_W-1:0] t);
        longint eff_len;
        longint eff_cnt;
        longint one;
        longint pos;
        longint tap_i;
        longint frac;
        longint s0;
        longint s1;
        longint acc;
        one = longint'(1) <<< FRAC;
        acc = 0;
        eff_len = longint'(len_q);
        if (eff_len < 1)
            eff_len = 1;
        if (eff_len > N_SAMP)
            eff_len = N_SAMP;
        eff_cnt = (cnt_q > N_RX) ? N_RX : longint'(cnt_q);
        for (int g = 0; g < eff_cnt; g++)
        begin
            pos = (longint'(t) <<< FRAC) - longint'(g) * longint'(step_q);
            if (pos >= 0)
            begin
                tap_i = pos >>> FRAC;
                if (tap_i == eff_len - 1)
                begin
                    s0 = rx_wave[g * N_SAMP + tap_i];
                    acc += s0;
                end
                else if (tap_i < eff_len - 1)
                begin
                    frac = pos & (one - 1);
                    s0 = rx_wave[g * N_SAMP + tap_i];
                    s1 = rx_wave[g * N_SAMP + tap_i + 1];
                    acc += (s0 * (one - frac) + s1 * frac) >>> FRAC;
                end
            end
        end
        if (acc > AMP_MAX)
            acc = AMP_MAX;
        if (acc < AMP_MIN)
            acc = AMP_MIN;
        return acc[AMP_W-1:0];
    endfunction

    function automatic logic [TIME_W-1:0] window_time();
        int t;
        t = win_base + $urandom_range(0, WINDOW - 1);
        if (t > N_SAMP - 1)
            t = N_SAMP - 1;
        return t[TIME_W-1:0];
    endfunction

    // sender bursts: after a burst runs out, lower valid for a random gap
    task automatic pace();
        int gap;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic send_word(input logic wk, input logic [RX_W-1:0] wrx,
                             input logic [TIME_W-1:0] wt,
                             input logic signed [SAMPLE_W-1:0] ws,
                             input logic pinned, input logic signed [AMP_W-1:0] pinned_amp);
        in_valid       <= 1'b1;
        kind           <= wk;
        receiver_index <= wrx;
        time_index     <= wt;
        sample_value   <= ws;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        words_sent++;
        if (wk == KIND_RECORD)
            rx_wave[{wrx, wt}] = ws;
        else
        begin
            amp_expect.push_back(pinned ? pinned_amp : steered_sum(wt));
            synth_sent++;
        end
        pace();
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (amp_expect.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_DELAY_STEP:     step_q = data[STEP_W-1:0];
            REG_RECORD_LENGTH:  len_q  = data[LEN_W-1:0];
            REG_RECEIVER_COUNT: cnt_q  = data[CNT_W-1:0];
            default: ;
        endcase
    endtask

    // output side: stall pattern in runs, plus the long hold-off on request
    initial
    begin
        int run_left;
        int pct;
        out_stall = 1'b0;
        run_left  = 0;
        pct       = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
                holds_done++;
            end
            else
            begin
                if (run_left == 0)
                begin
                    run_left = $urandom_range(4, 80);
                    case ($urandom_range(0, 4))
                        0, 1:    pct = 0;
                        2:       pct = 25;
                        3:       pct = 60;
                        default: pct = 90;
                    endcase
                end
                run_left--;
                out_stall <= ($urandom_range(0, 99) < pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (amp_expect.size() == 0)
            begin
                if (fail_count < 10)
                    $display("%0t: amplitude word %0d with nothing pending", $realtime,
                             amplitude);
                fail_count++;
            end
            else if (amplitude !== amp_expect[0])
            begin
                if (fail_count < 10)
                    $display("%0t: amplitude mismatch, expected %0d, got %0d", $realtime,
                             amp_expect[0], amplitude);
                fail_count++;
                void'(amp_expect.pop_front());
            end
            else
                void'(amp_expect.pop_front());
        end
    end

    initial
    begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("timeout with %0d results pending", amp_expect.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        int st;
        int ln;
        int ct;
        int eff_len;
        int sent;
        int r;
        int vmode;
        logic [TIME_W-1:0] col_t;
        logic signed [SAMPLE_W-1:0] sv;
        logic [10:0] len_junk;
        logic [18:0] cnt_junk;

        rst_n          = 1'b0;
        in_valid       = 1'b0;
        kind           = KIND_RECORD;
        receiver_index = '0;
        time_index     = '0;
        sample_value   = '0;
        cfg_write      = 1'b0;
        cfg_index      = REG_DELAY_STEP;
        cfg_data       = '0;
        foreach (rx_wave[a])
            rx_wave[a] = '0;
        step_q = '0;
        len_q  = LEN_RESET;
        cnt_q  = CNT_RESET;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // directed rows under the reset settings; the first one waits out the clear
        for (int i = 0; i < PROBE_ROWS; i++)
            send_word(probe_rows[i].kind, probe_rows[i].rx, probe_rows[i].t, probe_rows[i].s,
                      probe_rows[i].pinned, probe_rows[i].amp);
        drain();

        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            case (ph)
                0: begin st = 65536;    ln = 4096; ct = 16; end
                1: begin st = -8388608; ln = 4096; ct = 16; end
                2: begin st = 8388607;  ln = 8191; ct = 31; end
                3: begin st = 16384;    ln = 0;    ct = 1;  end
                4: begin st = -98304;   ln = 1;    ct = 0;  end
                5: begin st = 12345;    ln = 2;    ct = 16; end
                6: begin st = -40000;   ln = 4097; ct = 17; end
                default:
                begin
                    if ($urandom_range(0, 4) == 0)
                        st = $urandom_range(0, 24'hFFFFFF);
                    else
                    begin
                        st = $urandom_range(0, 4 * 65536);
                        if ($urandom_range(0, 1) == 1)
                            st = -st;
                    end
                    ln = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191)
                                                     : $urandom_range(1, 64);
                    ct = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 16)
                                                     : $urandom_range(0, 31);
                end
            endcase
            // unused upper bits of the write data carry noise in the random phases
            len_junk = (ph < N_FIXED) ? '0 : 11'($urandom);
            cnt_junk = (ph < N_FIXED) ? '0 : 19'($urandom);
            cfg_put(REG_DELAY_STEP, st[STEP_W-1:0]);
            cfg_put(REG_RECORD_LENGTH, {len_junk, ln[LEN_W-1:0]});
            cfg_put(REG_RECEIVER_COUNT, {cnt_junk, ct[CNT_W-1:0]});
            if (ph == 4)
                cfg_put(REG_SPARE, CFG_DATA_W'($urandom));

            eff_len = (ln < 1) ? 1 : ((ln > N_SAMP) ? N_SAMP : ln);
            if ($urandom_range(0, 3) == 0)
                win_base = (eff_len > 12) ? eff_len - 12 : 0;
            else
                win_base = $urandom_range(0, eff_len - 1);

            if (ph == HOLD_PHASE)
                hold_req = 1'b1;

            sent = 0;
            while (sent < PHASE_WORDS)
            begin
                r = $urandom_range(0, 99);
                if (r < 10)
                begin
                    send_word(1'($urandom), 4'($urandom), 12'($urandom), 16'($urandom),
                              1'b0, '0);
                    sent++;
                end
                else if (r < 18)
                begin
                    // fill one column across all receivers, then synthesize at it
                    col_t = window_time();
                    vmode = $urandom_range(0, 2);
                    for (int g = 0; g < N_RX; g++)
                    begin
                        sv = (vmode == 0) ? 16'($urandom)
                           : ((vmode == 1) ? 16'sh7FFF : 16'sh8000);
                        send_word(KIND_RECORD, 4'(g), col_t, sv, 1'b0, '0);
                    end
                    send_word(KIND_SYNTH, 4'($urandom), col_t, 16'($urandom), 1'b0, '0);
                    send_word(KIND_SYNTH, 4'($urandom), window_time(), 16'($urandom),
                              1'b0, '0);
                    sent += N_RX + 2;
                end
                else if (r < 60)
                begin
                    case ($urandom_range(0, 7))
                        0:       sv = 16'sh7FFF;
                        1:       sv = 16'sh8000;
                        default: sv = 16'($urandom);
                    endcase
                    send_word(KIND_RECORD, 4'($urandom), window_time(), sv, 1'b0, '0);
                    sent++;
                end
                else
                begin
                    send_word(KIND_SYNTH, 4'($urandom), window_time(), 16'($urandom),
                              1'b0, '0);
                    sent++;
                end
            end
            drain();
        end

        $display("sent %0d words, %0d synth results checked, reset table plus %0d settings",
                 words_sent, results_seen, N_PHASES);
        $display("long output hold-offs: %0d", holds_done);
        if (fail_count == 0 && amp_expect.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
